// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// All checks sample on clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge.
`define BCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// If the trigger holds at one edge, the consequence must hold at the next.
`define BCS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bcs_pkg.sv =====
package bcs_pkg;

    // Command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PAUSE = 2'd1;
    localparam logic [1:0] OP_SHOW  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Set pointer codes, lowest digit first
    localparam logic [2:0] PTR_HUNDREDTHS = 3'd0;
    localparam logic [2:0] PTR_TENTHS     = 3'd1;
    localparam logic [2:0] PTR_SEC_UNITS  = 3'd2;
    localparam logic [2:0] PTR_SEC_TENS   = 3'd3;
    localparam logic [2:0] PTR_MIN_UNITS  = 3'd4;
    localparam logic [2:0] PTR_MIN_TENS   = 3'd5;

    // Digit limits
    localparam logic [3:0] LIMIT_DEC = 4'd9;
    localparam logic [2:0] LIMIT_SIX = 3'd5;

    typedef struct packed {
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic [2:0] sec_tens;
        logic [3:0] sec_units;
        logic [3:0] tenths;
        logic [3:0] hundredths;
    } time_t;

    // Reset value: 59:59.99
    localparam time_t TIME_RESET = '{
        min_tens:   LIMIT_SIX,
        min_units:  LIMIT_DEC,
        sec_tens:   LIMIT_SIX,
        sec_units:  LIMIT_DEC,
        tenths:     LIMIT_DEC,
        hundredths: LIMIT_DEC
    };

    // One command beat leaving the input stage
    typedef struct packed {
        logic       fire;
        logic [1:0] op;
        logic [9:0] switches;
    } step_t;

endpackage

// ===== hw/rtl/bcs_if.sv =====
// Command channel
interface bcs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [9:0] switches;

    modport source (output valid, op, switches, input ready);
    modport sink (input valid, op, switches, output ready);
endinterface

// Response channel
interface bcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] hundredths;
    logic [3:0] tenths;
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic       paused;

    modport source (output valid, hundredths, tenths, sec_units, sec_tens, min_units,
                    min_tens, paused, input ready);
    modport sink (input valid, hundredths, tenths, sec_units, sec_tens, min_units,
                  min_tens, paused, output ready);
endinterface

// ===== hw/rtl/bcd_countdown_stopwatch.sv =====
// Channel  Dir  Payload                                       Beat
// cmd      in   op[1:0], switches[9:0]                        valid & ready
// rsp      out  hundredths, tenths, sec_units, sec_tens,      valid & ready
//               min_units, min_tens, paused
//
// One command per cycle while cmd.ready is high; a show command's response passes
// through the input register, then the response register.
// Reset shows 59:59.99, running, set pointer on hundredths.
// A show waiting on a full, unaccepted response register holds the input
// register, and cmd.ready drops until the response is taken.
// Ticks, pause toggles and no-ops never stall on the response side.
module bcd_countdown_stopwatch (
    input  logic          clk,
    input  logic          rst_n,
    bcs_cmd_if.sink       cmd,
    bcs_rsp_if.source     rsp
);

    logic           stage_valid_reg;
    logic [1:0]     stage_op_reg;
    logic [9:0]     stage_sw_reg;
    logic           stage_is_show;
    logic           stage_fire;

    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    bcs_pkg::time_t rsp_time_reg;
    logic           rsp_paused_reg;

    bcs_pkg::step_t step;
    bcs_pkg::time_t shown;
    logic           paused;

    // Input stage advances unless a show is blocked by a full response
    assign stage_is_show = stage_op_reg == bcs_pkg::OP_SHOW;
    assign stage_fire    = stage_valid_reg &&
                           (!stage_is_show || !rsp_valid_reg || rsp.ready);
    assign cmd.ready     = !stage_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            stage_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            stage_op_reg <= cmd.op;
            stage_sw_reg <= cmd.switches;
        end
    end

    assign step.fire     = stage_fire;
    assign step.op       = stage_op_reg;
    assign step.switches = stage_sw_reg;

    bcs_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .shown  (shown),
        .paused (paused)
    );

    // Response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (stage_fire && stage_is_show)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && stage_is_show)
        begin
            rsp_time_reg   <= shown;
            rsp_paused_reg <= paused;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hundredths = rsp_time_reg.hundredths;
    assign rsp.tenths     = rsp_time_reg.tenths;
    assign rsp.sec_units  = rsp_time_reg.sec_units;
    assign rsp.sec_tens   = rsp_time_reg.sec_tens;
    assign rsp.min_units  = rsp_time_reg.min_units;
    assign rsp.min_tens   = rsp_time_reg.min_tens;
    assign rsp.paused     = rsp_paused_reg;

endmodule

// ===== hw/rtl/bcs_timer.sv =====
`include "assert_macros.svh"

module bcs_timer (
    input  logic           clk,
    input  logic           rst_n,
    input  bcs_pkg::step_t step,
    output bcs_pkg::time_t shown,
    output logic           paused
);

    bcs_pkg::time_t digits_reg;
    bcs_pkg::time_t digits_next;
    logic           paused_reg;
    logic           paused_next;
    logic [2:0]     ptr_reg;
    logic [2:0]     ptr_next;

    logic           do_tick;
    logic           do_set;
    logic [5:0]     borrow;
    logic           fits_dec;
    logic           fits_six;

    logic           digits_ok;
    logic           pause_beat;
    logic           paused_tick;
    logic           ptr_home;

    assign do_tick  = step.fire && (step.op == bcs_pkg::OP_TICK) && !paused_reg;
    assign do_set   = step.fire && (step.op == bcs_pkg::OP_SHOW) && paused_reg;
    assign fits_dec = step.switches <= {6'd0, bcs_pkg::LIMIT_DEC};
    assign fits_six = step.switches <= {7'd0, bcs_pkg::LIMIT_SIX};

    // Borrow ripple: each digit passes the borrow on when it was zero
    assign borrow[0] = do_tick;
    assign borrow[1] = borrow[0] && (digits_reg.hundredths == 4'd0);
    assign borrow[2] = borrow[1] && (digits_reg.tenths == 4'd0);
    assign borrow[3] = borrow[2] && (digits_reg.sec_units == 4'd0);
    assign borrow[4] = borrow[3] && (digits_reg.sec_tens == 3'd0);
    assign borrow[5] = borrow[4] && (digits_reg.min_units == 4'd0);

    // Next state: countdown, pause toggle, digit load
    always_comb
    begin
        digits_next = digits_reg;
        paused_next = paused_reg;
        ptr_next    = ptr_reg;

        if (borrow[0])
        begin
            digits_next.hundredths = (digits_reg.hundredths == 4'd0) ?
                bcs_pkg::LIMIT_DEC : digits_reg.hundredths - 4'd1;
        end
        if (borrow[1])
        begin
            digits_next.tenths = (digits_reg.tenths == 4'd0) ?
                bcs_pkg::LIMIT_DEC : digits_reg.tenths - 4'd1;
        end
        if (borrow[2])
        begin
            digits_next.sec_units = (digits_reg.sec_units == 4'd0) ?
                bcs_pkg::LIMIT_DEC : digits_reg.sec_units - 4'd1;
        end
        if (borrow[3])
        begin
            digits_next.sec_tens = (digits_reg.sec_tens == 3'd0) ?
                bcs_pkg::LIMIT_SIX : digits_reg.sec_tens - 3'd1;
        end
        if (borrow[4])
        begin
            digits_next.min_units = (digits_reg.min_units == 4'd0) ?
                bcs_pkg::LIMIT_DEC : digits_reg.min_units - 4'd1;
        end
        if (borrow[5])
        begin
            digits_next.min_tens = (digits_reg.min_tens == 3'd0) ?
                bcs_pkg::LIMIT_SIX : digits_reg.min_tens - 3'd1;
        end

        if (step.fire && (step.op == bcs_pkg::OP_PAUSE))
        begin
            paused_next = !paused_reg;
            ptr_next    = bcs_pkg::PTR_HUNDREDTHS;
        end

        // Load the pointed digit if the switch value is in range
        if (do_set)
        begin
            unique case (ptr_reg)
                bcs_pkg::PTR_HUNDREDTHS:
                begin
                    if (fits_dec)
                    begin
                        digits_next.hundredths = step.switches[3:0];
                        ptr_next = bcs_pkg::PTR_TENTHS;
                    end
                end
                bcs_pkg::PTR_TENTHS:
                begin
                    if (fits_dec)
                    begin
                        digits_next.tenths = step.switches[3:0];
                        ptr_next = bcs_pkg::PTR_SEC_UNITS;
                    end
                end
                bcs_pkg::PTR_SEC_UNITS:
                begin
                    if (fits_dec)
                    begin
                        digits_next.sec_units = step.switches[3:0];
                        ptr_next = bcs_pkg::PTR_SEC_TENS;
                    end
                end
                bcs_pkg::PTR_SEC_TENS:
                begin
                    if (fits_six)
                    begin
                        digits_next.sec_tens = step.switches[2:0];
                        ptr_next = bcs_pkg::PTR_MIN_UNITS;
                    end
                end
                bcs_pkg::PTR_MIN_UNITS:
                begin
                    if (fits_dec)
                    begin
                        digits_next.min_units = step.switches[3:0];
                        ptr_next = bcs_pkg::PTR_MIN_TENS;
                    end
                end
                bcs_pkg::PTR_MIN_TENS:
                begin
                    if (fits_six)
                    begin
                        digits_next.min_tens = step.switches[2:0];
                        ptr_next = bcs_pkg::PTR_HUNDREDTHS;
                    end
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= bcs_pkg::TIME_RESET;
            paused_reg <= 1'b0;
            ptr_reg    <= bcs_pkg::PTR_HUNDREDTHS;
        end
        else
        begin
            digits_reg <= digits_next;
            paused_reg <= paused_next;
            ptr_reg    <= ptr_next;
        end
    end

    // A show reports the time after any digit load
    assign shown  = digits_next;
    assign paused = paused_reg;

    // Terms for the checks below
    assign digits_ok   = (digits_reg.hundredths <= bcs_pkg::LIMIT_DEC) &&
                         (digits_reg.tenths <= bcs_pkg::LIMIT_DEC) &&
                         (digits_reg.sec_units <= bcs_pkg::LIMIT_DEC) &&
                         (digits_reg.sec_tens <= bcs_pkg::LIMIT_SIX) &&
                         (digits_reg.min_units <= bcs_pkg::LIMIT_DEC) &&
                         (digits_reg.min_tens <= bcs_pkg::LIMIT_SIX);
    assign pause_beat  = step.fire && (step.op == bcs_pkg::OP_PAUSE);
    assign paused_tick = step.fire && (step.op == bcs_pkg::OP_TICK) && paused_reg;
    assign ptr_home    = ptr_reg == bcs_pkg::PTR_HUNDREDTHS;

    `BCS_ASSERT(a_ptr_range, ptr_reg <= bcs_pkg::PTR_MIN_TENS, "set pointer out of range")
    `BCS_ASSERT(a_digit_range, digits_ok, "digit out of range")
    `BCS_ASSERT_NEXT(a_pause_clears_ptr, pause_beat, ptr_home, "pause toggle left pointer set")
    `BCS_ASSERT_NEXT(a_paused_tick_holds, paused_tick, $stable(digits_reg), "paused tick moved time")

endmodule

// ===== bench/bcs_countdown_checker.sv =====
// Watches the command and response channels of the countdown timer, keeps its
// own copy of the shown time, and compares every response beat with the
// oldest predicted time report.
module bcs_countdown_checker (
    input  logic clk,
    input  logic rst_n,
    bcs_cmd_if   cmd,
    bcs_rsp_if   rsp,
    output int   fails,
    output int   pending,
    output int   reports
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bcs_pkg::time_t shown;
        logic           paused;
    } time_report_t;

    // Predicted timer state
    bcs_pkg::time_t clock_now;
    logic           paused_now;
    logic [2:0]     set_ptr;
    logic           borrow;
    logic           loaded;
    time_report_t   report_q[$];
    time_report_t   want;
    int             mismatch_count;
    int             compared;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_now      = bcs_pkg::TIME_RESET;
            paused_now     = 1'b0;
            set_ptr        = bcs_pkg::PTR_HUNDREDTHS;
            mismatch_count = 0;
            compared       = 0;
            report_q.delete();
        end
        else
        begin
            // Response beat: compare with oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (report_q.size() == 0)
                begin
                    report_mismatch("unexpected response beat", 1, 0);
                end
                else
                begin
                    want = report_q.pop_front();
                    compared++;
                    if (rsp.hundredths !== want.shown.hundredths)
                        report_mismatch("hundredths", rsp.hundredths, want.shown.hundredths);
                    if (rsp.tenths !== want.shown.tenths)
                        report_mismatch("tenths", rsp.tenths, want.shown.tenths);
                    if (rsp.sec_units !== want.shown.sec_units)
                        report_mismatch("sec_units", rsp.sec_units, want.shown.sec_units);
                    if (rsp.sec_tens !== want.shown.sec_tens)
                        report_mismatch("sec_tens", rsp.sec_tens, want.shown.sec_tens);
                    if (rsp.min_units !== want.shown.min_units)
                        report_mismatch("min_units", rsp.min_units, want.shown.min_units);
                    if (rsp.min_tens !== want.shown.min_tens)
                        report_mismatch("min_tens", rsp.min_tens, want.shown.min_tens);
                    if (rsp.paused !== want.paused)
                        report_mismatch("paused", rsp.paused, want.paused);
                end
            end

            // Command beat: advance the predicted state
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.op)
                    bcs_pkg::OP_TICK:
                    begin
                        // borrow ripples upward, each digit wraps to its limit
                        if (!paused_now)
                        begin
                            borrow = (clock_now.hundredths == 0);
                            clock_now.hundredths = borrow ? bcs_pkg::LIMIT_DEC
                                                          : clock_now.hundredths - 4'd1;
                            if (borrow)
                            begin
                                borrow = (clock_now.tenths == 0);
                                clock_now.tenths = borrow ? bcs_pkg::LIMIT_DEC
                                                          : clock_now.tenths - 4'd1;
                            end
                            if (borrow)
                            begin
                                borrow = (clock_now.sec_units == 0);
                                clock_now.sec_units = borrow ? bcs_pkg::LIMIT_DEC
                                                             : clock_now.sec_units - 4'd1;
                            end
                            if (borrow)
                            begin
                                borrow = (clock_now.sec_tens == 0);
                                clock_now.sec_tens = borrow ? bcs_pkg::LIMIT_SIX
                                                            : clock_now.sec_tens - 3'd1;
                            end
                            if (borrow)
                            begin
                                borrow = (clock_now.min_units == 0);
                                clock_now.min_units = borrow ? bcs_pkg::LIMIT_DEC
                                                             : clock_now.min_units - 4'd1;
                            end
                            if (borrow)
                            begin
                                clock_now.min_tens = (clock_now.min_tens == 0)
                                                   ? bcs_pkg::LIMIT_SIX
                                                   : clock_now.min_tens - 3'd1;
                            end
                        end
                    end
                    bcs_pkg::OP_PAUSE:
                    begin
                        paused_now = ~paused_now;
                        set_ptr    = bcs_pkg::PTR_HUNDREDTHS;
                    end
                    bcs_pkg::OP_SHOW:
                    begin
                        // while paused, load the digit under the pointer if in range
                        if (paused_now)
                        begin
                            loaded = 1'b0;
                            case (set_ptr)
                                bcs_pkg::PTR_HUNDREDTHS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_DEC)
                                    begin
                                        clock_now.hundredths = cmd.switches[3:0];
                                        loaded = 1'b1;
                                    end
                                bcs_pkg::PTR_TENTHS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_DEC)
                                    begin
                                        clock_now.tenths = cmd.switches[3:0];
                                        loaded = 1'b1;
                                    end
                                bcs_pkg::PTR_SEC_UNITS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_DEC)
                                    begin
                                        clock_now.sec_units = cmd.switches[3:0];
                                        loaded = 1'b1;
                                    end
                                bcs_pkg::PTR_SEC_TENS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_SIX)
                                    begin
                                        clock_now.sec_tens = cmd.switches[2:0];
                                        loaded = 1'b1;
                                    end
                                bcs_pkg::PTR_MIN_UNITS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_DEC)
                                    begin
                                        clock_now.min_units = cmd.switches[3:0];
                                        loaded = 1'b1;
                                    end
                                bcs_pkg::PTR_MIN_TENS:
                                    if (cmd.switches <= bcs_pkg::LIMIT_SIX)
                                    begin
                                        clock_now.min_tens = cmd.switches[2:0];
                                        loaded = 1'b1;
                                    end
                                default: ;
                            endcase
                            if (loaded)
                                set_ptr = (set_ptr == bcs_pkg::PTR_MIN_TENS)
                                        ? bcs_pkg::PTR_HUNDREDTHS
                                        : set_ptr + 3'd1;
                        end
                        report_q.push_back('{shown: clock_now, paused: paused_now});
                    end
                    default: ;
                endcase
            end
        end

        // counters seen by the top are registered copies
        fails   <= mismatch_count;
        pending <= report_q.size();
        reports <= compared;
    end

endmodule

// ===== bench/tb_bcd_countdown_stopwatch.sv =====
// Drives commands into the countdown timer, stalls the response side at
// random, and gives the verdict from the checker's counts.
module tb_bcd_countdown_stopwatch;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;

    bcs_cmd_if cmd_ch ();
    bcs_rsp_if rsp_ch ();

    int   fails;
    int   pending;
    int   reports;
    int   beats_sent;
    int   counted;
    int   set_runs;
    logic calm;
    logic tb_paused;

    bcd_countdown_stopwatch dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    bcs_countdown_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .fails   (fails),
        .pending (pending),
        .reports (reports)
    );

    always #6ns clk = ~clk;

    // Largest legal value of each digit, hundredths first
    function automatic int digit_limit(input int idx);
        return (idx == 3 || idx == 5) ? 5 : 9;
    endfunction

    // One command beat, with an occasional one-cycle gap ahead of it
    task automatic send_beat(input logic [1:0] op, input logic [9:0] sw);
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= op;
        cmd_ch.switches <= sw;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        beats_sent++;
        if (op == bcs_pkg::OP_PAUSE)
            tb_paused = ~tb_paused;
        if (op != bcs_pkg::OP_NOP && !(op == bcs_pkg::OP_TICK && tb_paused))
            counted++;
    endtask

    // Response side: random stalls, none while calm
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
        end
    end

    initial
    begin
        #4ms;
        $display("tb_bcd_countdown_stopwatch NOT OK");
        $finish;
    end

    initial
    begin
        int sw_val;
        int lim;
        int n;
        int kind;

        rst_n           = 1'b0;
        calm            = 1'b0;
        tb_paused       = 1'b0;
        beats_sent      = 0;
        counted         = 0;
        set_runs        = 0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.op       = bcs_pkg::OP_NOP;
        cmd_ch.switches = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset value, running show, no-ops, paused tick
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_TICK, 10'h3FF);
        send_beat(bcs_pkg::OP_SHOW, 10'h3FF);
        send_beat(bcs_pkg::OP_NOP, 10'h155);
        send_beat(bcs_pkg::OP_SHOW, 10'h2AA);
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);
        send_beat(bcs_pkg::OP_TICK, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd10);
        // load all zeros; seconds tens first refuses an over-limit six
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd6);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        // run: wrap from 00:00.00 to 59:59.99
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);
        send_beat(bcs_pkg::OP_TICK, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd0);
        // load every digit at its limit, then pointer wraps to hundredths
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);
        for (int d = 0; d < 6; d++)
            send_beat(bcs_pkg::OP_SHOW, 10'(digit_limit(d)));
        send_beat(bcs_pkg::OP_SHOW, 10'd3);
        // pause toggles put the pointer back on hundredths
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);
        send_beat(bcs_pkg::OP_SHOW, 10'd4);
        send_beat(bcs_pkg::OP_PAUSE, 10'd0);

        // Random: mostly pause-load-run sequences, some mixed noise
        while (counted < 620)
        begin
            calm = (counted >= 260 && counted < 400);
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                set_runs++;
                if (!tb_paused)
                    send_beat(bcs_pkg::OP_PAUSE, 10'($urandom));
                for (int d = 0; d < 6; d++)
                begin
                    lim = digit_limit(d);
                    n   = $urandom_range(0, 9);
                    if (n < 6)
                        sw_val = 0;
                    else if (n < 9)
                        sw_val = $urandom_range(0, lim);
                    else
                        sw_val = $urandom_range(lim + 1, 1023);
                    send_beat(bcs_pkg::OP_SHOW, 10'(sw_val));
                end
                send_beat(bcs_pkg::OP_PAUSE, 10'($urandom));
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) < 3)
                        send_beat(bcs_pkg::OP_SHOW, 10'($urandom));
                    else
                        send_beat(bcs_pkg::OP_TICK, 10'($urandom));
                end
            end
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    sw_val = $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 9);
                    send_beat(2'($urandom_range(0, 3)), 10'(sw_val));
                end
            end
        end
        cmd_ch.valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding reports, then let the pipeline settle
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d command beats (%0d load-and-run sequences)", beats_sent, set_runs);
        $display("compared %0d time reports, %0d mismatches", reports, fails);
        if (fails == 0)
            $display("tb_bcd_countdown_stopwatch OK");
        else
            $display("tb_bcd_countdown_stopwatch NOT OK");
        $finish;
    end

endmodule
